FILE: hdl/flv_tsp_pkg.sv
// ----------------------------------------------------------------------------
// FLV tag stream parser package
// Shared types and constants for the FLV tag stream parser.
// ----------------------------------------------------------------------------
package flv_tsp_pkg;

  localparam int unsigned OffsetBits   = 40;
  localparam int unsigned TagOffsetW   = 40;
  localparam int unsigned PreambleLen  = 4 + 9;
  localparam int unsigned HdrLastByte  = 10;
  localparam int unsigned HdrShiftLen  = 8;
  localparam int unsigned TrailerLen   = 4;

  localparam logic [7:0] TagAudio  = 8'h08;
  localparam logic [7:0] TagVideo  = 8'h09;
  localparam logic [7:0] TagScript = 8'h12;

  localparam logic [3:0] CodecAac = 4'd10;
  localparam logic [3:0] CodecAvc = 4'd7;

  localparam logic [7:0] SigF = 8'h46;
  localparam logic [7:0] SigL = 8'h4c;
  localparam logic [7:0] SigV = 8'h56;

  typedef enum logic [1:0] {
    KIND_AUDIO  = 2'd0,
    KIND_VIDEO  = 2'd1,
    KIND_SCRIPT = 2'd2,
    KIND_OTHER  = 2'd3
  } tag_kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SHORT   = 2'd1,
    STATUS_BAD_SIG = 2'd2
  } status_e;

  typedef enum logic [5:0] {
    PH_PRE  = 6'b000001,
    PH_HDR  = 6'b000010,
    PH_PFX  = 6'b000100,
    PH_SKIP = 6'b001000,
    PH_TRL  = 6'b010000,
    PH_FAIL = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [1:0]            tag_kind;
    logic [23:0]           payload_size;
    logic [31:0]           time_stamp;
    logic [3:0]            codec_id;
    logic [3:0]            frame_type;
    logic [7:0]            packet_type;
    logic [23:0]           composition_offset;
    logic [23:0]           media_size;
    logic                  is_config;
    logic [1:0]            stream_flags;
    logic [TagOffsetW-1:0] tag_offset;
    logic [1:0]            status;
  } result_t;

endpackage

FILE: hdl/flv_tsp_if.sv
// ----------------------------------------------------------------------------
// FLV tag stream parser channels
// Byte input channel and tag result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface flv_tsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface flv_tsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  tag_kind;
  logic [23:0] payload_size;
  logic [31:0] time_stamp;
  logic [3:0]  codec_id;
  logic [3:0]  frame_type;
  logic [7:0]  packet_type;
  logic [23:0] composition_offset;
  logic [23:0] media_size;
  logic        is_config;
  logic [1:0]  stream_flags;
  logic [39:0] tag_offset;
  logic [1:0]  status;

  modport source (
    output valid, output tag_kind, output payload_size, output time_stamp,
    output codec_id, output frame_type, output packet_type,
    output composition_offset, output media_size, output is_config,
    output stream_flags, output tag_offset, output status, input ready
  );
  modport sink (
    input valid, input tag_kind, input payload_size, input time_stamp,
    input codec_id, input frame_type, input packet_type,
    input composition_offset, input media_size, input is_config,
    input stream_flags, input tag_offset, input status, output ready
  );
endinterface

FILE: hdl/flv_tag_stream_parser.sv
// ----------------------------------------------------------------------------
// FLV tag stream parser
// Walks an FLV byte stream and reports one header record per tag.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one file byte per word, start_of_file marks byte zero and restarts
//           the parser on that same byte.
//   out_o : one tag record per word. Media tags report once the codec prefix
//           is in (or the payload ran out); other tags at their last header
//           byte. A bad signature yields one record with status 2, then the
//           file is ignored until the next start_of_file.
//   Throughput: one byte per cycle while the result buffer has room, set by the
//   combinational next-state logic between the parser state registers and the result buffer.
//   Output: a record enters the result buffer when the byte that completes it
//   is accepted, and reaches out_o once the records ahead of it are taken.
//   Stall: a two-word result buffer (output register plus skid) sits in front
//   of out_o; in_i.ready drops only while both words are held.
//   Reset: parser returns to the signature check, offset counter cleared,
//   result buffer emptied.
// ----------------------------------------------------------------------------
module flv_tag_stream_parser import flv_tsp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  flv_tsp_in_if.sink    in_i,
  flv_tsp_out_if.source out_o
);

  localparam logic [OffsetBits-1:0] PosMax = '1;
  localparam logic [63:0] Lim64 = 64'((65'd1 << TagOffsetW) - 65'd1);

  phase_e                phase_q, phase_d;
  logic [23:0]           cnt_q, cnt_d;
  logic [63:0]           hdr_q, hdr_d;
  logic [39:0]           pfx_q, pfx_d;
  logic [OffsetBits-1:0] pos_q, pos_d;
  logic [OffsetBits-1:0] start_q, start_d;
  logic [1:0]            flags_q, flags_d;
  logic                  sigfail_q, sigfail_d;

  logic    accept, buf_ready, emit;
  result_t res;

  // Left-justify the first n prefix bytes; bytes not yet seen read as zero.
  function automatic logic [39:0] align_pfx(logic [39:0] ps, logic [2:0] n);
    logic [39:0] al;
    unique case (n)
      3'd1:    al = {ps[7:0], 32'b0};
      3'd2:    al = {ps[15:0], 24'b0};
      3'd3:    al = {ps[23:0], 16'b0};
      3'd4:    al = {ps[31:0], 8'b0};
      3'd5:    al = ps;
      default: al = '0;
    endcase
    return al;
  endfunction

  function automatic logic [2:0] prefix_len(logic [7:0] ty, logic [7:0] b0);
    logic [2:0] len;
    if (ty == TagAudio) begin
      len = (b0[7:4] == CodecAac) ? 3'd2 : 3'd1;
    end else if (ty == TagVideo) begin
      len = (b0[3:0] == CodecAvc) ? 3'd5 : 3'd1;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  function automatic logic [7:0] sig_byte(logic [1:0] idx);
    logic [7:0] s;
    unique case (idx)
      2'd0:    s = SigF;
      2'd1:    s = SigL;
      default: s = SigV;
    endcase
    return s;
  endfunction

  function automatic result_t build(logic [63:0] hs, logic [39:0] ps, logic [2:0] n,
                                    logic [2:0] full, logic [1:0] fl,
                                    logic [OffsetBits-1:0] st);
    result_t     r;
    logic [39:0] al;
    logic [7:0]  ty;
    logic [23:0] size;
    logic [63:0] st64;
    al   = align_pfx(ps, n);
    ty   = hs[63:56];
    size = hs[55:32];
    st64 = 64'(st);
    r    = '0;
    if (ty == TagAudio && n >= 3'd1) begin
      r.codec_id = al[39:36];
      if (al[39:36] == CodecAac && n >= 3'd2) begin
        r.packet_type = al[31:24];
        r.is_config   = (al[31:24] == 8'd0);
      end
    end else if (ty == TagVideo && n >= 3'd1) begin
      r.codec_id   = al[35:32];
      r.frame_type = al[39:36];
      if (al[35:32] == CodecAvc) begin
        if (n >= 3'd2) begin
          r.packet_type = al[31:24];
          r.is_config   = (al[31:24] == 8'd0);
        end
        if (n >= 3'd5) r.composition_offset = al[23:0];
      end
    end
    if (ty == TagAudio)       r.tag_kind = KIND_AUDIO;
    else if (ty == TagVideo)  r.tag_kind = KIND_VIDEO;
    else if (ty == TagScript) r.tag_kind = KIND_SCRIPT;
    else                      r.tag_kind = KIND_OTHER;
    r.payload_size = size;
    r.time_stamp   = {hs[7:0], hs[31:8]};
    r.media_size   = (size >= 24'(full)) ? size - 24'(full) : 24'd0;
    r.stream_flags = fl;
    r.tag_offset   = (st64 > Lim64) ? Lim64[TagOffsetW-1:0] : st64[TagOffsetW-1:0];
    r.status       = (size < 24'(full)) ? STATUS_SHORT : STATUS_OK;
    return r;
  endfunction

  assign accept = in_i.valid && buf_ready;
  assign in_i.ready = buf_ready;

  always_comb begin
    phase_e                ph;
    logic [23:0]           cnt;
    logic [63:0]           hs;
    logic [39:0]           ps;
    logic [OffsetBits-1:0] pos;
    logic [OffsetBits-1:0] st;
    logic [1:0]            fl;
    logic                  sf;
    logic [7:0]            b;
    logic [2:0]            n;
    logic [2:0]            full;
    logic [23:0]           size;
    logic [39:0]           al;

    b = in_i.data_byte;
    // start_of_file restarts the parser on this very byte
    if (in_i.start_of_file) begin
      ph = PH_PRE; cnt = '0; hs = '0; ps = '0; pos = '0; st = '0; fl = '0; sf = 1'b0;
    end else begin
      ph = phase_q; cnt = cnt_q; hs = hdr_q; ps = pfx_q; pos = pos_q;
      st = start_q; fl = flags_q; sf = sigfail_q;
    end

    phase_d   = ph;
    cnt_d     = cnt;
    hdr_d     = hs;
    pfx_d     = ps;
    start_d   = st;
    flags_d   = fl;
    sigfail_d = sf;
    pos_d     = (pos < PosMax) ? pos + OffsetBits'(1) : pos;
    emit      = 1'b0;
    res       = '0;
    n         = '0;
    full      = '0;
    size      = hs[55:32];
    al        = '0;

    unique case (ph)
      PH_PRE: begin
        if (cnt < 24'd3 && b != sig_byte(cnt[1:0])) sigfail_d = 1'b1;
        if (cnt == 24'd2 && sigfail_d) begin
          emit       = 1'b1;
          res.status = STATUS_BAD_SIG;
          phase_d    = PH_FAIL;
        end else begin
          if (cnt == 24'd4) flags_d = {b[2], b[0]};
          cnt_d = cnt + 24'd1;
          if (cnt_d >= 24'(PreambleLen)) begin
            phase_d = PH_HDR;
            cnt_d   = '0;
          end
        end
      end
      PH_HDR: begin
        if (cnt == 24'd0) begin
          start_d = pos;
          hdr_d   = '0;
        end
        if (cnt < 24'(HdrShiftLen)) hdr_d = {hdr_d[55:0], b};
        size = hdr_d[55:32];
        if (cnt >= 24'(HdrLastByte)) begin
          pfx_d = '0;
          cnt_d = '0;
          if (hdr_d[63:56] == TagAudio || hdr_d[63:56] == TagVideo) begin
            if (size == 24'd0) begin
              emit    = 1'b1;
              res     = build(hdr_d, '0, 3'd0, 3'd1, flags_d, start_d);
              phase_d = PH_TRL;
            end else begin
              phase_d = PH_PFX;
            end
          end else begin
            emit    = 1'b1;
            res     = build(hdr_d, '0, 3'd0, 3'd0, flags_d, start_d);
            phase_d = (size != 24'd0) ? PH_SKIP : PH_TRL;
          end
        end else begin
          cnt_d = cnt + 24'd1;
        end
      end
      PH_PFX: begin
        n     = cnt[2:0] + 3'd1;
        pfx_d = {ps[31:0], b};
        al    = align_pfx(pfx_d, n);
        full  = prefix_len(hs[63:56], al[39:32]);
        if (n >= full || 24'(n) >= size) begin
          emit = 1'b1;
          res  = build(hs, pfx_d, n, full, fl, st);
          if (24'(n) >= size) begin
            phase_d = PH_TRL;
            cnt_d   = '0;
          end else begin
            phase_d = PH_SKIP;
            cnt_d   = 24'(n);
          end
        end else begin
          cnt_d = 24'(n);
        end
      end
      PH_SKIP: begin
        cnt_d = cnt + 24'd1;
        if (cnt_d >= size) begin
          phase_d = PH_TRL;
          cnt_d   = '0;
        end
      end
      PH_TRL: begin
        cnt_d = cnt + 24'd1;
        if (cnt_d >= 24'(TrailerLen)) begin
          phase_d = PH_HDR;
          cnt_d   = '0;
        end
      end
      default: begin
        // failed signature: bytes are dropped until start_of_file
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_PRE;
      cnt_q     <= '0;
      hdr_q     <= '0;
      pfx_q     <= '0;
      pos_q     <= '0;
      start_q   <= '0;
      flags_q   <= '0;
      sigfail_q <= 1'b0;
    end else if (accept) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      hdr_q     <= hdr_d;
      pfx_q     <= pfx_d;
      pos_q     <= pos_d;
      start_q   <= start_d;
      flags_q   <= flags_d;
      sigfail_q <= sigfail_d;
    end
  end

  result_t out_data;

  flv_tsp_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && emit),
    .push_data_i (res),
    .ready_o     (buf_ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign out_o.tag_kind           = out_data.tag_kind;
  assign out_o.payload_size       = out_data.payload_size;
  assign out_o.time_stamp         = out_data.time_stamp;
  assign out_o.codec_id           = out_data.codec_id;
  assign out_o.frame_type         = out_data.frame_type;
  assign out_o.packet_type        = out_data.packet_type;
  assign out_o.composition_offset = out_data.composition_offset;
  assign out_o.media_size         = out_data.media_size;
  assign out_o.is_config          = out_data.is_config;
  assign out_o.stream_flags       = out_data.stream_flags;
  assign out_o.tag_offset         = out_data.tag_offset;
  assign out_o.status             = out_data.status;

endmodule

FILE: hdl/flv_tsp_result_buf.sv
// ----------------------------------------------------------------------------
// FLV tag result buffer
// Output register plus skid register; keeps the parser running while the
// receiver stalls on a pending result, until the skid register is also full.
// ----------------------------------------------------------------------------
module flv_tsp_result_buf import flv_tsp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    main_valid_q, skid_valid_q;
  result_t main_data_q, skid_data_q;
  logic    pop;

  assign pop         = main_valid_q && out_ready_i;
  assign ready_o     = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= push_i;
      end else begin
        main_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (!main_valid_q) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        main_data_q <= skid_data_q;
        skid_data_q <= push_data_i;
      end else begin
        main_data_q <= push_data_i;
      end
    end else if (push_i) begin
      if (!main_valid_q) begin
        main_data_q <= push_data_i;
      end else begin
        skid_data_q <= push_data_i;
      end
    end
  end

endmodule
